// File: hdl/toeq_pkg.sv
// Shared types and constants for the time-ordered event queue.
package toeq_pkg;

    localparam int QUEUE_DEPTH = 16;
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

    localparam int TIME_W   = 32;
    localparam int ACTION_W = 8;
    localparam int TAG_W    = 16;
    localparam int STATUS_W = 2;

    localparam logic REQ_INSERT = 1'b0;
    localparam logic REQ_POP    = 1'b1;

    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

    typedef struct packed {
        logic [TIME_W-1:0]   ev_time;
        logic [ACTION_W-1:0] action;
        logic [TAG_W-1:0]    tag;
    } t_entry;

    typedef struct packed {
        logic   ins;
        logic   pop;
        t_entry item;
    } t_cell_ctl;

endpackage

// File: hdl/toeq_cell.sv
// One slot of the sorted queue: holds an entry, keeps, loads or shifts it.
module toeq_cell (
    input  logic               i_clk,
    input  toeq_pkg::t_cell_ctl i_ctl,
    input  logic               i_occ,
    input  logic               i_left_le,
    input  toeq_pkg::t_entry   i_left,
    input  toeq_pkg::t_entry   i_right,
    output toeq_pkg::t_entry   o_entry,
    output logic               o_le
);
    import toeq_pkg::*;

    t_entry r_entry;
    t_entry n_entry;

    assign o_le    = i_occ && (r_entry.ev_time <= i_ctl.item.ev_time);
    assign o_entry = r_entry;

    always_comb begin
        n_entry = r_entry;
        if (i_ctl.pop) begin
            n_entry = i_right;
        end else if (i_ctl.ins && !o_le) begin
            if (i_left_le) begin
                n_entry = i_ctl.item;
            end else begin
                n_entry = i_left;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

endmodule

// File: hdl/time_ordered_event_queue_core.sv
// Top level of the time-ordered event queue: cell chain, fill count and result register.
//
//  channel   direction  signals                                          transfer when
//  request   in         start, i_req_type, i_event_time, i_action_code,  start && !busy
//                       i_event_tag
//  result    out        o_done, o_status, o_out_time, o_out_action,      o_done
//                       o_out_tag
//
// One request per cycle; every cell compares against the new time in parallel.
// The result appears in the cycle after the request transfer, high for one cycle.
// busy stays low: the chain of cells finishes each insert or pop before the next request.
// Reset clears the fill count and the result strobe; slot contents are left as they are.
// The receiver cannot stall; each result is taken in the cycle it is shown.
module time_ordered_event_queue_core (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic                          i_req_type,
    input  logic [toeq_pkg::TIME_W-1:0]   i_event_time,
    input  logic [toeq_pkg::ACTION_W-1:0] i_action_code,
    input  logic [toeq_pkg::TAG_W-1:0]    i_event_tag,
    output logic                          o_done,
    output logic [toeq_pkg::STATUS_W-1:0] o_status,
    output logic [toeq_pkg::TIME_W-1:0]   o_out_time,
    output logic [toeq_pkg::ACTION_W-1:0] o_out_action,
    output logic [toeq_pkg::TAG_W-1:0]    o_out_tag
);
    import toeq_pkg::*;

    logic [CNT_W-1:0]    r_count;
    logic [CNT_W-1:0]    n_count;
    logic                r_done;
    logic [STATUS_W-1:0] r_status;
    logic [STATUS_W-1:0] n_status;
    t_entry              r_out;
    t_entry              n_out;

    t_cell_ctl           ctl;
    logic                take;
    logic                full;
    logic                empty;
    t_entry              cell_q  [QUEUE_DEPTH];
    logic                cell_le [QUEUE_DEPTH];

    assign busy  = 1'b0;
    assign take  = start && !busy;
    assign full  = (r_count == CNT_W'(QUEUE_DEPTH));
    assign empty = (r_count == '0);

    assign ctl.ins          = take && (i_req_type == REQ_INSERT) && !full;
    assign ctl.pop          = take && (i_req_type == REQ_POP) && !empty;
    assign ctl.item.ev_time = i_event_time;
    assign ctl.item.action  = i_action_code;
    assign ctl.item.tag     = i_event_tag;

    for (genvar g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
        logic   left_le;
        t_entry left_q;
        t_entry right_q;

        if (g == 0) begin : g_first
            assign left_le = 1'b1;
            assign left_q  = cell_q[0];
        end else begin : g_mid
            assign left_le = cell_le[g-1];
            assign left_q  = cell_q[g-1];
        end

        if (g == QUEUE_DEPTH - 1) begin : g_last
            assign right_q = cell_q[g];
        end else begin : g_inner
            assign right_q = cell_q[g+1];
        end

        toeq_cell u_cell (
            .i_clk     (i_clk),
            .i_ctl     (ctl),
            .i_occ     (CNT_W'(g) < r_count),
            .i_left_le (left_le),
            .i_left    (left_q),
            .i_right   (right_q),
            .o_entry   (cell_q[g]),
            .o_le      (cell_le[g])
        );
    end

    always_comb begin
        n_count  = r_count;
        n_status = ST_OK;
        n_out    = '0;
        if (take) begin
            if (i_req_type == REQ_INSERT) begin
                if (full) begin
                    n_status = ST_FULL;
                end else begin
                    n_count = r_count + 1'b1;
                end
            end else begin
                if (empty) begin
                    n_status = ST_EMPTY;
                end else begin
                    n_count = r_count - 1'b1;
                    n_out   = cell_q[0];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_done  <= 1'b0;
        end else begin
            r_count <= n_count;
            r_done  <= take;
        end
        r_status <= n_status;
        r_out    <= n_out;
    end

    assign o_done       = r_done;
    assign o_status     = r_status;
    assign o_out_time   = r_out.ev_time;
    assign o_out_action = r_out.action;
    assign o_out_tag    = r_out.tag;

    a_done_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        take |=> o_done)
        else $error("result strobe missing after request transfer");

    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !take |=> !o_done)
        else $error("result strobe without request transfer");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(QUEUE_DEPTH))
        else $error("fill count beyond queue depth");

    a_empty_pop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (take && i_req_type == REQ_POP && empty) |=> (o_status == ST_EMPTY && $stable(r_count)))
        else $error("pop of empty queue mishandled");

    a_full_ins: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (take && i_req_type == REQ_INSERT && full) |=> (o_status == ST_FULL && $stable(r_count)))
        else $error("insert into full queue mishandled");

endmodule
